// ===== hw/rtl/iol_pkg.sv =====
package iol_pkg;

   // fixed widths of the stream fields
   localparam int POS_W     = 17;
   localparam int VALUE_W   = 32;
   localparam int STATUS_W  = 2;
   localparam int CNT_OUT_W = 5;
   localparam int REQ_TDATA_W = 56;  // position + value, padded to whole bytes
   localparam int RSP_TDATA_W = 40;  // removed_value + entry_count + is_empty, padded

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_DELETE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic             start;
      logic [POS_W-1:0] dividend;
   } rem_req_type;

endpackage

// ===== hw/rtl/iol_rem.sv =====
module iol_rem
   import iol_pkg::*;
#(
   parameter int DIV_W = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  rem_req_type      req,
   input  logic [DIV_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] remainder
);

   localparam int STEP_W = $clog2(POS_W + 1);

   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [POS_W-1:0]  dvd_ff, dvd_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_W:0]    trial;

   // one restoring step per cycle: shift in a dividend bit, subtract if it fits
   assign trial = {rem_ff, dvd_ff[POS_W-1]};

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         dvd_in  = req.dividend;
         step_in = STEP_W'(POS_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = DIV_W'(trial - {1'b0, divisor});
         end else begin
            rem_in = DIV_W'(trial);
         end
         dvd_in  = {dvd_ff[POS_W-2:0], 1'b0};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== hw/rtl/iol_ram.sv =====
module iol_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/indexed_ordered_list_unit.sv =====
// Each accepted req beat is checked first: an insert into a full list is dropped and a delete
// on an empty list is refused at once. Else a negative position is first reduced modulo the
// count, then the entries are shifted one by one (at most CAPACITY-1 moved) and the rsp is set.
// No new req beat is taken before the unit is through with the last one; req_tready is high
// only while the sequencer is idle. Reset (synchronous, active high) empties the list and
// clears the control state; the entry memory is not cleared and needs no clearing pass.
module indexed_ordered_list_unit
   import iol_pkg::*;
#(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // position[16:0], value[48:17], zero pad
   input  logic                   req_tuser,  // mode
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // removed_value[31:0], entry_count[36:32],
                                              // is_empty[37], zero pad
   output logic [STATUS_W-1:0]    rsp_tuser   // status
);

   localparam int AW    = $clog2(CAPACITY);
   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CW >= POS_W) ? CW + 1 : POS_W;

   typedef enum logic [11:0] {
      S_IDLE     = 12'b0000_0000_0001,
      S_CHECK    = 12'b0000_0000_0010,
      S_MOD      = 12'b0000_0000_0100,
      S_PLAN     = 12'b0000_0000_1000,
      S_INS_LOOP = 12'b0000_0001_0000,
      S_INS_WR   = 12'b0000_0010_0000,
      S_PUT      = 12'b0000_0100_0000,
      S_DEL_TAKE = 12'b0000_1000_0000,
      S_DEL_GOT  = 12'b0001_0000_0000,
      S_DEL_LOOP = 12'b0010_0000_0000,
      S_DEL_WR   = 12'b0100_0000_0000,
      S_FINISH   = 12'b1000_0000_0000
   } state_type;

   state_type               state_ff, state_in;
   logic                    mode_ff, mode_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [DATA_WIDTH-1:0]   val_ff, val_in;
   logic [CW-1:0]           n_ff, n_in;
   logic [AW-1:0]           slot_ff, slot_in;
   logic [AW-1:0]           idx_ff, idx_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic [DATA_WIDTH-1:0]   removed_ff, removed_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]      rsp_removed_ff, rsp_removed_in;
   logic [CNT_OUT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                    rsp_empty_ff, rsp_empty_in;

   rem_req_type             rem_req;
   logic                    rem_done;
   logic [CW-1:0]           rem_m;

   logic                    ram_we;
   logic [AW-1:0]           ram_waddr;
   logic [DATA_WIDTH-1:0]   ram_wdata;
   logic [AW-1:0]           ram_raddr;
   logic [DATA_WIDTH-1:0]   ram_rdata;

   logic                    pos_neg;
   logic [CMP_W-1:0]        pos_wide;
   logic [CMP_W-1:0]        n_wide;
   logic [AW-1:0]           pos_slot;
   logic [AW-1:0]           ins_slot;
   logic [AW-1:0]           del_slot;
   logic [CW-1:0]           count_next;

   assign pos_neg  = pos_ff[POS_W-1];
   assign pos_wide = CMP_W'(pos_ff[POS_W-2:0]);
   assign n_wide   = CMP_W'(n_ff);
   assign pos_slot = AW'(pos_ff[POS_W-2:0] - (POS_W-1)'(1));

   always_comb begin
      if (n_ff == '0) begin
         ins_slot = '0;
      end else if (!pos_neg && pos_wide > n_wide) begin
         ins_slot = AW'(n_ff);
      end else if (!pos_neg && pos_wide <= CMP_W'(1)) begin
         ins_slot = '0;
      end else if (pos_neg) begin
         if (rem_m == CW'(1)) begin
            ins_slot = AW'(n_ff);
         end else if (rem_m == '0) begin
            ins_slot = '0;
         end else begin
            ins_slot = AW'(n_ff + CW'(1) - rem_m);
         end
      end else begin
         ins_slot = pos_slot;
      end
   end

   always_comb begin
      if (!pos_neg && pos_wide >= n_wide) begin
         del_slot = AW'(n_ff - CW'(1));
      end else if (!pos_neg && pos_wide <= CMP_W'(1)) begin
         del_slot = '0;
      end else if (pos_neg) begin
         if (rem_m == CW'(1)) begin
            del_slot = AW'(n_ff - CW'(1));
         end else if (rem_m == '0) begin
            del_slot = '0;
         end else begin
            del_slot = AW'(n_ff - rem_m);
         end
      end else begin
         del_slot = pos_slot;
      end
   end

   always_comb begin
      if (status_ff != ST_DONE) begin
         count_next = n_ff;
      end else if (mode_ff == MODE_INSERT) begin
         count_next = n_ff + CW'(1);
      end else begin
         count_next = n_ff - CW'(1);
      end
   end

   always_comb begin
      case (state_ff)
         S_INS_LOOP: ram_raddr = idx_ff - AW'(1);
         S_DEL_TAKE: ram_raddr = slot_ff;
         S_DEL_LOOP: ram_raddr = idx_ff + AW'(1);
         default:    ram_raddr = '0;
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      pos_in         = pos_ff;
      val_in         = val_ff;
      n_in           = n_ff;
      slot_in        = slot_ff;
      idx_in         = idx_ff;
      status_in      = status_ff;
      removed_in     = removed_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_empty_in   = rsp_empty_ff;
      rem_req.start    = 1'b0;
      rem_req.dividend = POS_W'(~pos_ff + POS_W'(1));
      ram_we    = 1'b0;
      ram_waddr = idx_ff;
      ram_wdata = ram_rdata;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               mode_in  = req_tuser;
               pos_in   = req_tdata[POS_W-1:0];
               val_in   = DATA_WIDTH'(req_tdata[POS_W +: VALUE_W]);
               n_in     = count_ff;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            status_in  = ST_DONE;
            removed_in = '0;
            if (mode_ff == MODE_INSERT && n_ff == CW'(CAPACITY)) begin
               status_in = ST_FULL;
               state_in  = S_FINISH;
            end else if (mode_ff == MODE_DELETE && n_ff == '0) begin
               status_in = ST_EMPTY;
               state_in  = S_FINISH;
            end else if (pos_neg && n_ff != '0) begin
               rem_req.start = 1'b1;
               state_in      = S_MOD;
            end else begin
               state_in = S_PLAN;
            end
         end
         S_MOD: begin
            if (rem_done) begin
               state_in = S_PLAN;
            end
         end
         S_PLAN: begin
            if (mode_ff == MODE_INSERT) begin
               slot_in  = ins_slot;
               idx_in   = AW'(n_ff);
               state_in = S_INS_LOOP;
            end else begin
               slot_in  = del_slot;
               idx_in   = del_slot;
               state_in = S_DEL_TAKE;
            end
         end
         // open a hole: move entries up from the end down to the slot
         S_INS_LOOP: begin
            if (idx_ff > slot_ff) begin
               state_in = S_INS_WR;
            end else begin
               state_in = S_PUT;
            end
         end
         S_INS_WR: begin
            ram_we   = 1'b1;
            idx_in   = idx_ff - AW'(1);
            state_in = S_INS_LOOP;
         end
         S_PUT: begin
            ram_we    = 1'b1;
            ram_waddr = slot_ff;
            ram_wdata = val_ff;
            state_in  = S_FINISH;
         end
         S_DEL_TAKE: begin
            state_in = S_DEL_GOT;
         end
         S_DEL_GOT: begin
            removed_in = ram_rdata;
            state_in   = S_DEL_LOOP;
         end
         // close the gap: move entries down from the slot to the end
         S_DEL_LOOP: begin
            if (CW'(idx_ff) + CW'(1) < n_ff) begin
               state_in = S_DEL_WR;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_DEL_WR: begin
            ram_we   = 1'b1;
            idx_in   = idx_ff + AW'(1);
            state_in = S_DEL_LOOP;
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               count_in       = count_next;
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_removed_in = VALUE_W'(removed_ff);
               rsp_count_in   = CNT_OUT_W'(count_next);
               rsp_empty_in   = (count_next == '0);
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff        <= mode_in;
      pos_ff         <= pos_in;
      val_ff         <= val_in;
      n_ff           <= n_in;
      slot_ff        <= slot_in;
      idx_ff         <= idx_in;
      status_ff      <= status_in;
      removed_ff     <= removed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_empty_ff   <= rsp_empty_in;
   end

   iol_rem #(
      .DIV_W(CW)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .req       (rem_req),
      .divisor   (n_ff),
      .done      (rem_done),
      .remainder (rem_m)
   );

   iol_ram #(
      .DEPTH(CAPACITY),
      .WIDTH(DATA_WIDTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_empty_ff, rsp_count_ff, rsp_removed_ff});

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> CW'(ram_waddr) <= n_ff)
      else $error("memory write beyond the occupied range");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_FULL |-> count_ff == CW'(CAPACITY))
      else $error("full status with a list that is not full");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_EMPTY |-> count_ff == '0 && rsp_removed_ff == '0)
      else $error("empty status with entries held or a removed word");

   a_rem_in_range: assert property (@(posedge clock) disable iff (reset)
      rem_done |-> rem_m < n_ff)
      else $error("remainder not below the count");
`endif

endmodule
